// ===== hdl/tpsa_pkg.sv =====
package tpsa_pkg;

    localparam int DEF_PIXELS  = 65536;
    localparam int DEF_CLASSES = 4;

    localparam int SUM_W   = 37;
    localparam int SQ_W    = 51;
    localparam int COUNT_W = 20;
    localparam int QUOT_W  = 17;

    localparam logic [1:0] OP_FRAME_START = 2'd0;
    localparam logic [1:0] OP_ADD_PIXEL   = 2'd1;
    localparam logic [1:0] OP_READ_PIXEL  = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]         SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [COUNT_W-1:0]      COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         event_class;
        logic [15:0]        pixel_index;
        logic signed [15:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] pixel_sum;
        logic [SQ_W-1:0]         pixel_sum_squares;
        logic [COUNT_W-1:0]      frame_total;
        logic signed [15:0]      dark_mean;
    } out_item_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_RUN,
        DIV_ROUND
    } div_state_t;

endpackage

// ===== hdl/thresholded_pixel_sum_accumulator_top.sv =====
// Per-pixel, per-event-class accumulator of thresholded pixel values and their
// squares, with a saturating frame count per class. Items are offered on start
// and taken at an edge where busy is low. Frame-start and add-pixel items
// transfer one per cycle, back to back, when not busy: the sums live in two
// synchronous memories updated by read-modify-write, with the last write
// forwarded to the item right behind it. A read holds busy through stage 1
// and the divider's check, run and round states (no run if the pixel or class
// is out of range, the count is zero or the mean saturates early); the dark
// mean comes from a shared restoring divider that retires one quotient bit per
// cycle. Each result is shown for exactly one cycle with done high; the
// receiver cannot stall it, so capture it in that cycle. After reset the block
// holds busy while it sweeps zeros through all CLASSES*PIXELS entries (262144
// by default) of both memories; threshold writes are taken at any time.
module thresholded_pixel_sum_accumulator_top #(
    parameter int PIXELS  = tpsa_pkg::DEF_PIXELS,
    parameter int CLASSES = tpsa_pkg::DEF_CLASSES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tpsa_pkg::in_item_t  item,
    output logic                done,
    output tpsa_pkg::out_item_t result,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data
);

    localparam int DEPTH = CLASSES * PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int SUM_W = tpsa_pkg::SUM_W;
    localparam int SQ_W  = tpsa_pkg::SQ_W;
    localparam int CNT_W = tpsa_pkg::COUNT_W;
    localparam int QW    = tpsa_pkg::QUOT_W;

    // Threshold register
    logic signed [15:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_write)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // Input decode
    logic            accept;
    logic            cls_ok;
    logic            pix_ok;
    logic [CW-1:0]   cls_idx;
    logic [AW-1:0]   in_addr;
    logic            above;
    logic signed [31:0] in_square;

    assign accept    = start && !busy;
    assign cls_ok    = 32'(item.event_class) < 32'(CLASSES);
    assign pix_ok    = 32'(item.pixel_index) < 32'(PIXELS);
    assign cls_idx   = CW'(item.event_class);
    assign in_addr   = (cls_ok && pix_ok)
                     ? AW'(AW'(item.event_class) * AW'(PIXELS) + AW'(item.pixel_index))
                     : '0;
    assign above     = item.pixel_value > threshold_reg;
    assign in_square = item.pixel_value * item.pixel_value;

    // Frame counts: small, kept in flops
    logic [CNT_W-1:0] counts_reg [CLASSES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASSES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (accept && item.opcode == tpsa_pkg::OP_FRAME_START && cls_ok &&
                 counts_reg[cls_idx] != tpsa_pkg::COUNT_MAX)
        begin
            counts_reg[cls_idx] <= counts_reg[cls_idx] + CNT_W'(1);
        end
    end

    // Stage 1 control and payload
    logic             s1_valid_reg;
    logic [1:0]       s1_op_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_hit_reg;
    logic             s1_cls_ok_reg;
    logic             s1_above_reg;
    logic signed [15:0] s1_val_reg;
    logic [31:0]      s1_sq_reg;
    logic [CNT_W-1:0] s1_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (item.opcode == tpsa_pkg::OP_ADD_PIXEL ||
                                       item.opcode == tpsa_pkg::OP_READ_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= item.opcode;
            s1_addr_reg   <= in_addr;
            s1_hit_reg    <= cls_ok && pix_ok;
            s1_cls_ok_reg <= cls_ok;
            s1_above_reg  <= above;
            s1_val_reg    <= item.pixel_value;
            s1_sq_reg     <= 32'(in_square);
            s1_cnt_reg    <= cls_ok ? counts_reg[cls_idx] : '0;
        end
    end

    // Clearing pass after reset
    logic          clear_active_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clr_addr_reg     <= '0;
        end
        else if (clear_active_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clear_active_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Sum memories
    logic signed [SUM_W-1:0] sum_mem [DEPTH];
    logic [SQ_W-1:0]         sq_mem  [DEPTH];
    logic signed [SUM_W-1:0] rd_sum_reg;
    logic [SQ_W-1:0]         rd_sq_reg;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [SUM_W-1:0] mem_wsum;
    logic [SQ_W-1:0]         mem_wsq;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_waddr] <= mem_wsum;
            sq_mem[mem_waddr]  <= mem_wsq;
        end
        rd_sum_reg <= sum_mem[in_addr];
        rd_sq_reg  <= sq_mem[in_addr];
    end

    // Forward the last write to the item right behind it
    logic                    wb_valid_reg;
    logic [AW-1:0]           wb_addr_reg;
    logic signed [SUM_W-1:0] wb_sum_reg;
    logic [SQ_W-1:0]         wb_sq_reg;

    logic                    fwd;
    logic signed [SUM_W-1:0] cur_sum;
    logic [SQ_W-1:0]         cur_sq;
    logic signed [SUM_W:0]   add_sum;
    logic [SQ_W:0]           add_sq;
    logic signed [SUM_W-1:0] new_sum;
    logic [SQ_W-1:0]         new_sq;
    logic                    add_write;
    logic                    read_load;

    assign fwd     = wb_valid_reg && (wb_addr_reg == s1_addr_reg);
    assign cur_sum = fwd ? wb_sum_reg : rd_sum_reg;
    assign cur_sq  = fwd ? wb_sq_reg  : rd_sq_reg;
    assign add_sum = {cur_sum[SUM_W-1], cur_sum} + (SUM_W+1)'(s1_val_reg);
    assign add_sq  = {1'b0, cur_sq} + (SQ_W+1)'(s1_sq_reg);

    always_comb
    begin
        if (add_sum[SUM_W] != add_sum[SUM_W-1])
        begin
            new_sum = add_sum[SUM_W] ? tpsa_pkg::SUM_MIN : tpsa_pkg::SUM_MAX;
        end
        else
        begin
            new_sum = add_sum[SUM_W-1:0];
        end
        new_sq = add_sq[SQ_W] ? tpsa_pkg::SQ_MAX : add_sq[SQ_W-1:0];
    end

    assign add_write = s1_valid_reg && s1_op_reg == tpsa_pkg::OP_ADD_PIXEL &&
                       s1_hit_reg && s1_above_reg;
    assign read_load = s1_valid_reg && s1_op_reg == tpsa_pkg::OP_READ_PIXEL;

    assign mem_we    = clear_active_reg || add_write;
    assign mem_waddr = clear_active_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wsum  = clear_active_reg ? '0 : new_sum;
    assign mem_wsq   = clear_active_reg ? '0 : new_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= add_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_write)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_sum_reg  <= new_sum;
            wb_sq_reg   <= new_sq;
        end
    end

    // Dark-mean divider: restoring, one quotient bit per cycle
    tpsa_pkg::div_state_t div_state_reg, div_state_next;

    logic                    hold_sum_neg_reg;
    logic signed [SUM_W-1:0] hold_sum_reg;
    logic [SQ_W-1:0]         hold_sq_reg;
    logic [CNT_W-1:0]        hold_cnt_reg;
    logic                    zero_reg;
    logic                    ovf_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        den_shift_reg;
    logic [QW-1:0]           q_reg;
    logic [4:0]              step_reg;

    logic                    div_active;
    logic                    do_check;
    logic                    do_step;
    logic                    do_round;

    logic                    ovf_now;
    logic                    step_fits;
    logic [SUM_W-1:0]        load_sum;
    logic [SUM_W-1:0]        load_mag;

    assign load_sum  = s1_hit_reg ? cur_sum : '0;
    assign load_mag  = load_sum[SUM_W-1] ? SUM_W'(-load_sum) : load_sum;
    assign ovf_now   = rem_reg >= {hold_cnt_reg, {QW{1'b0}}};
    assign step_fits = rem_reg >= den_shift_reg;

    always_comb
    begin
        div_state_next = div_state_reg;
        unique case (div_state_reg)
            tpsa_pkg::DIV_IDLE:
            begin
                if (read_load)
                begin
                    div_state_next = tpsa_pkg::DIV_CHECK;
                end
            end
            tpsa_pkg::DIV_CHECK:
            begin
                if (zero_reg || ovf_now)
                begin
                    div_state_next = tpsa_pkg::DIV_ROUND;
                end
                else
                begin
                    div_state_next = tpsa_pkg::DIV_RUN;
                end
            end
            tpsa_pkg::DIV_RUN:
            begin
                if (step_reg == 5'd0)
                begin
                    div_state_next = tpsa_pkg::DIV_ROUND;
                end
            end
            tpsa_pkg::DIV_ROUND:
            begin
                div_state_next = tpsa_pkg::DIV_IDLE;
            end
            default:
            begin
                div_state_next = tpsa_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_active = 1'b1;
        do_check   = 1'b0;
        do_step    = 1'b0;
        do_round   = 1'b0;
        unique case (div_state_reg)
            tpsa_pkg::DIV_IDLE:  div_active = 1'b0;
            tpsa_pkg::DIV_CHECK: do_check   = 1'b1;
            tpsa_pkg::DIV_RUN:   do_step    = 1'b1;
            tpsa_pkg::DIV_ROUND: do_round   = 1'b1;
            default:             div_active = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= tpsa_pkg::DIV_IDLE;
        end
        else
        begin
            div_state_reg <= div_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_load && !div_active)
        begin
            hold_sum_neg_reg <= load_sum[SUM_W-1];
            hold_sum_reg     <= load_sum;
            hold_sq_reg      <= s1_hit_reg ? cur_sq : '0;
            hold_cnt_reg     <= s1_cnt_reg;
            zero_reg         <= !s1_hit_reg || !s1_cls_ok_reg || s1_cnt_reg == '0;
            ovf_reg          <= 1'b0;
            rem_reg          <= load_mag;
            den_shift_reg    <= {1'b0, s1_cnt_reg, {(QW-1){1'b0}}};
            q_reg            <= '0;
            step_reg         <= 5'(QW - 1);
        end
        if (do_check)
        begin
            ovf_reg <= ovf_now;
        end
        if (do_step)
        begin
            if (step_fits)
            begin
                rem_reg <= rem_reg - den_shift_reg;
            end
            q_reg         <= {q_reg[QW-2:0], step_fits};
            den_shift_reg <= den_shift_reg >> 1;
            step_reg      <= step_reg - 5'd1;
        end
    end

    // Round half to even, apply sign, saturate to int16
    logic [CNT_W:0]     two_r;
    logic               round_up;
    logic [QW:0]        q_round;
    logic signed [15:0] mean;

    assign two_r    = {rem_reg[CNT_W-1:0], 1'b0};
    assign round_up = (two_r > {1'b0, hold_cnt_reg}) ||
                      (two_r == {1'b0, hold_cnt_reg} && q_reg[0]);
    assign q_round  = {1'b0, q_reg} + (QW+1)'(round_up);

    always_comb
    begin
        if (zero_reg)
        begin
            mean = '0;
        end
        else if (hold_sum_neg_reg)
        begin
            if (ovf_reg || q_round > (QW+1)'(32768))
            begin
                mean = 16'sh8000;
            end
            else
            begin
                mean = 16'(-q_round);
            end
        end
        else
        begin
            if (ovf_reg || q_round > (QW+1)'(32767))
            begin
                mean = 16'sh7FFF;
            end
            else
            begin
                mean = q_round[15:0];
            end
        end
    end

    // Result register: one-cycle strobe
    logic                done_reg;
    tpsa_pkg::out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= do_round;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_round)
        begin
            result_reg.pixel_sum         <= hold_sum_reg;
            result_reg.pixel_sum_squares <= hold_sq_reg;
            result_reg.frame_total       <= hold_cnt_reg;
            result_reg.dark_mean         <= mean;
        end
    end

    // Hold off transfers during the clear, while a read waits in stage 1,
    // and while the divider works
    assign busy   = clear_active_reg || read_load || div_active;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/tb_thresholded_pixel_sum_accumulator_top.sv =====
`timescale 1ns / 100ps

module tb_thresholded_pixel_sum_accumulator_top;

    localparam int DEF_PIXELS   = tpsa_pkg::DEF_PIXELS;
    localparam int DEF_CLASSES  = tpsa_pkg::DEF_CLASSES;
    localparam int SUM_W        = tpsa_pkg::SUM_W;
    localparam int SQ_W         = tpsa_pkg::SQ_W;
    localparam int CNT_W        = tpsa_pkg::COUNT_W;
    localparam int ENTRY_COUNT  = DEF_CLASSES * DEF_PIXELS;
    // Covers the longest read occupancy, with margin for the add pipeline.
    localparam int DRAIN_CYCLES = 40;
    localparam int HOT_COUNT    = 8;
    // Opcode with no meaning; the block drops it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Command side, held at known values from time zero.
    logic                start     = 1'b0;
    tpsa_pkg::in_item_t  item      = '0;
    logic                cfg_write = 1'b0;
    logic [15:0]         cfg_data  = '0;

    // Result side.
    logic                busy;
    logic                done;
    tpsa_pkg::out_item_t result;

    // Predicted block state: per-pixel sums, frame counts and the threshold.
    longint          pixel_sums    [0:ENTRY_COUNT-1];
    longint unsigned pixel_squares [0:ENTRY_COUNT-1];
    int unsigned     class_frames  [0:DEF_CLASSES-1];
    logic signed [15:0] threshold_model = '0;

    // Pixel totals still owed by the block, oldest first.
    tpsa_pkg::out_item_t expected_totals[$];
    tpsa_pkg::out_item_t want_totals;

    logic [15:0] hot_pixels [0:HOT_COUNT-1];
    bit          no_idle = 1'b0;
    int          mismatch_count = 0;

    thresholded_pixel_sum_accumulator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // 2 ns period: one delay high, one delay low.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Rounded dark mean: sum / count, round half to even, clamp to int16,
    // zero when no frames have been counted.
    function automatic logic signed [15:0] dark_mean_of(input longint s, input longint c);
        longint mag;
        longint quo;
        longint rem;
        longint m;
        if (c == 0)
            return '0;
        mag = (s < 0) ? -s : s;
        quo = mag / c;
        rem = mag % c;
        if ((2 * rem > c) || ((2 * rem == c) && (quo % 2 == 1)))
            quo++;
        m = (s < 0) ? -quo : quo;
        if (m > 32767)
            m = 32767;
        if (m < -32768)
            m = -32768;
        return m[15:0];
    endfunction

    // Advance the predicted state by one transferred command; queue the
    // totals that a read will return. Class and pixel fields always fall in
    // range at the default sizes, so no range guard is needed here.
    task automatic predict_item(input tpsa_pkg::in_item_t it);
        int                  addr;
        longint              v;
        longint              s;
        longint unsigned     q;
        tpsa_pkg::out_item_t t;
        addr = int'({it.event_class, it.pixel_index});
        v    = longint'($signed(it.pixel_value));
        case (it.opcode)
            tpsa_pkg::OP_FRAME_START:
            begin
                if (class_frames[it.event_class] < tpsa_pkg::COUNT_MAX)
                    class_frames[it.event_class]++;
            end
            tpsa_pkg::OP_ADD_PIXEL:
            begin
                if (v > longint'(threshold_model))
                begin
                    s = pixel_sums[addr] + v;
                    q = pixel_squares[addr] + longint'(v * v);
                    if (s > longint'(tpsa_pkg::SUM_MAX))
                        s = longint'(tpsa_pkg::SUM_MAX);
                    if (s < longint'(tpsa_pkg::SUM_MIN))
                        s = longint'(tpsa_pkg::SUM_MIN);
                    if (q > longint'(tpsa_pkg::SQ_MAX))
                        q = longint'(tpsa_pkg::SQ_MAX);
                    pixel_sums[addr]    = s;
                    pixel_squares[addr] = q;
                end
            end
            tpsa_pkg::OP_READ_PIXEL:
            begin
                t.pixel_sum         = SUM_W'(pixel_sums[addr]);
                t.pixel_sum_squares = SQ_W'(pixel_squares[addr]);
                t.frame_total       = CNT_W'(class_frames[it.event_class]);
                t.dark_mean         = dark_mean_of(pixel_sums[addr],
                                                   longint'(class_frames[it.event_class]));
                expected_totals.push_back(t);
            end
            default:
            begin
                // Unused opcode: the block drops it.
            end
        endcase
    endtask

    // Offer one command and hold it until the block transfers it. A random
    // gap before the command lowers start first; back to back, start stays
    // high so that it gets one assignment per edge.
    task automatic send_item(input tpsa_pkg::in_item_t it);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 35)
            gap = int'($urandom_range(1, ($urandom_range(3) == 0) ? 30 : 3));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [1:0] cls,
                               input logic [15:0] pix, input logic signed [15:0] val);
        tpsa_pkg::in_item_t it;
        it.opcode      = op;
        it.event_class = cls;
        it.pixel_index = pix;
        it.pixel_value = val;
        send_item(it);
    endtask

    // Drop start, wait for every owed result, then let the add pipeline
    // settle, since frame-start and add commands return nothing.
    task automatic drain_block();
        start <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the threshold only with the block idle.
    task automatic set_threshold(input logic signed [15:0] thr);
        drain_block();
        cfg_write <= 1'b1;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_write <= 1'b0;
        threshold_model = thr;
    endtask

    function automatic logic signed [15:0] pick_value();
        int sel;
        sel = int'($urandom_range(99));
        if (sel < 40)
            return 16'($urandom);
        if (sel < 60)
        begin
            case ($urandom_range(5))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh8001;
                3: return 16'sh0000;
                4: return 16'sh0001;
                default: return 16'shffff;
            endcase
        end
        return 16'($urandom_range(600) - 300);
    endfunction

    // Mostly frame starts, adds and reads on a few hot pixels so that reads
    // see built-up sums; the rest lands anywhere in the frame.
    task automatic run_random_items(input int n_items);
        tpsa_pkg::in_item_t it;
        int                 sel;
        for (int i = 0; i < n_items; i++)
        begin
            sel = int'($urandom_range(99));
            if (sel < 15)
                it.opcode = tpsa_pkg::OP_FRAME_START;
            else if (sel < 63)
                it.opcode = tpsa_pkg::OP_ADD_PIXEL;
            else if (sel < 95)
                it.opcode = tpsa_pkg::OP_READ_PIXEL;
            else
                it.opcode = OP_UNUSED;
            it.event_class = 2'($urandom_range(DEF_CLASSES - 1));
            if ($urandom_range(99) < 70)
                it.pixel_index = hot_pixels[$urandom_range(HOT_COUNT - 1)];
            else
                it.pixel_index = 16'($urandom);
            it.pixel_value = pick_value();
            send_item(it);
        end
    endtask

    // Extremes of every field, each opcode, rounding ties both ways, and the
    // mean clamping at both ends.
    task automatic test_directed_cases();
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd0, 16'd0,     16'sd0);
        send_fields(tpsa_pkg::OP_FRAME_START, 2'd1, 16'd0,     16'sd0);
        send_fields(tpsa_pkg::OP_FRAME_START, 2'd1, 16'd0,     16'sd0);
        // Count 2: means of 1.5, 0.5 and 2.5 round to even.
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd1, 16'd5,     16'sd3);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd1, 16'd5,     16'sd0);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd1, 16'd6,     16'sd1);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd1, 16'd6,     16'sd0);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd1, 16'd7,     16'sd5);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd1, 16'd7,     16'sd0);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd1, 16'd7,     16'sd0);
        // Count 1 with a sum past int16: mean clamps high.
        send_fields(tpsa_pkg::OP_FRAME_START, 2'd2, 16'd0,     16'sd0);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd2, 16'hffff,  16'sh7fff);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd2, 16'hffff,  16'sh7fff);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd2, 16'hffff,  16'sd0);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd2, 16'd0,     16'sh8000);
        send_fields(OP_UNUSED,                2'd2, 16'd0,     16'sh7fff);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd2, 16'd0,     16'sd0);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd3, 16'hffff,  16'sd0);
        // Lowest threshold: negative sums, mean clamps low, -32768 still held out.
        set_threshold(16'sh8000);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd2, 16'd1,     16'sh8001);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd2, 16'd1,     16'sh8001);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd2, 16'd1,     16'sh8000);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd2, 16'd1,     16'sd0);
        send_fields(tpsa_pkg::OP_ADD_PIXEL,   2'd1, 16'd8,     -16'sd3);
        send_fields(tpsa_pkg::OP_READ_PIXEL,  2'd1, 16'd8,     16'sd0);
    endtask

    // Random traffic under several thresholds, the highest among them.
    task automatic test_threshold_sweep();
        set_threshold(16'sd0);
        run_random_items(300);
        set_threshold(16'sh7fff);
        run_random_items(200);
        set_threshold(16'($urandom));
        run_random_items(300);
        set_threshold(16'($urandom_range(200) - 100));
        run_random_items(300);
    endtask

    // A long stretch with start held high whenever there is work.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random_items(300);
        no_idle = 1'b0;
    endtask

    task automatic test_lowest_threshold();
        set_threshold(16'sh8000);
        run_random_items(400);
    endtask

    // Check each strobed result against the oldest owed totals.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_totals.size() == 0)
                report_mismatch("result with nothing owed", longint'(1), longint'(0));
            else
            begin
                want_totals = expected_totals.pop_front();
                if (result.pixel_sum !== want_totals.pixel_sum)
                    report_mismatch("pixel_sum", longint'(result.pixel_sum),
                                    longint'(want_totals.pixel_sum));
                if (result.pixel_sum_squares !== want_totals.pixel_sum_squares)
                    report_mismatch("pixel_sum_squares", longint'(result.pixel_sum_squares),
                                    longint'(want_totals.pixel_sum_squares));
                if (result.frame_total !== want_totals.frame_total)
                    report_mismatch("frame_total", longint'(result.frame_total),
                                    longint'(want_totals.frame_total));
                if (result.dark_mean !== want_totals.dark_mean)
                    report_mismatch("dark_mean", longint'(result.dark_mean),
                                    longint'(want_totals.dark_mean));
            end
        end
    end

    initial
    begin
        hot_pixels[0] = 16'd0;
        hot_pixels[1] = 16'hffff;
        for (int i = 2; i < HOT_COUNT; i++)
            hot_pixels[i] = 16'($urandom);

        // Hold reset first; the block then clears its memories while busy is high,
        // and the first transfer waits that out.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_threshold_sweep();
        test_back_to_back();
        test_lowest_threshold();

        drain_block();
        if (mismatch_count == 0 && expected_totals.size() == 0)
            $display("tb_thresholded_pixel_sum_accumulator_top: PASS");
        else
            $display("tb_thresholded_pixel_sum_accumulator_top: FAIL");
        $finish;
    end

    // Hard stop: the limit allows several times what the memory clear plus the
    // command traffic take, even with every command a full-length read behind
    // the longest gap.
    initial
    begin
        #4_000_000;
        $display("tb_thresholded_pixel_sum_accumulator_top: FAIL");
        $finish;
    end

endmodule
